>>> hdl/ordered_set_succ_pred_top_assert.svh
// ----------------------------------------------------------------------------
// ordered_set_succ_pred_top_assert
// Assertion macros for the ordered set block.
// ----------------------------------------------------------------------------
`ifndef ORDERED_SET_SUCC_PRED_TOP_ASSERT_SVH
`define ORDERED_SET_SUCC_PRED_TOP_ASSERT_SVH

// Same-cycle implication.
`define OSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define OSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/osp_pkg.sv
// ----------------------------------------------------------------------------
// osp_pkg
// Types and constants shared by the ordered set cell chain and its control.
// ----------------------------------------------------------------------------
package osp_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_W        = 32;
	localparam int GRP_CELLS    = 8;

	typedef enum logic [2:0] {
		OP_INS     = 3'd0,
		OP_DEL     = 3'd1,
		OP_MIN     = 3'd2,
		OP_MAX     = 3'd3,
		OP_SUCC    = 3'd4,
		OP_SUCC_EQ = 3'd5,
		OP_PRED    = 3'd6,
		OP_PRED_EQ = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_RED
	} state_t;

	typedef struct packed {
		op_t  op;
		logic do_ins;
		logic do_del;
		logic capture;
	} chain_ctl_t;

	typedef struct packed {
		logic any_eq;
		logic hit;
	} chain_sts_t;

endpackage

>>> hdl/ordered_set_succ_pred_top.sv
// Flow: an accepted request beat is compared in every cell, then goes through
// the OR-tree reduction, then the output register, to its response beat.
// The sequencer holds the cell row for one operation at a time, so a new request
// is not taken until the last one is loaded out; a stalled response holds it.
// Reset: arst_n clears the key count and all control state; stored keys are
// not cleared, cells at or above the count never feed a compare or an answer.
// ----------------------------------------------------------------------------
// ordered_set_succ_pred_top
// Sorted set of distinct signed keys with insert, delete, min, max and
// successor / predecessor queries, built on a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
`include "ordered_set_succ_pred_top_assert.svh"

module ordered_set_succ_pred_top #(
	parameter int CAPACITY = osp_pkg::CAPACITY_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  logic        [2:0]                    kind,
	input  logic signed [osp_pkg::KEY_W-1:0]     key,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output logic signed [osp_pkg::KEY_W-1:0]     value,
	output logic                                 found,
	output logic                                 full_res
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	osp_pkg::state_t     state_q, state_d;
	osp_pkg::op_t        op_q;
	logic signed [osp_pkg::KEY_W-1:0] key_q;
	logic [CNT_W-1:0]    cnt_q;
	osp_pkg::chain_ctl_t ctl;
	osp_pkg::chain_sts_t sts;
	logic [osp_pkg::KEY_W-1:0] res_value;
	logic                full_set;
	logic                upd_found_s1, full_s1;
	logic                load_out;
	logic                rsp_valid_q;
	logic signed [osp_pkg::KEY_W-1:0] value_q;
	logic                found_q, full_q;

	assign full_set = cnt_q == CNT_W'(CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= osp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		load_out    = 1'b0;
		ctl.op      = op_q;
		ctl.do_ins  = 1'b0;
		ctl.do_del  = 1'b0;
		ctl.capture = 1'b0;
		unique case (state_q)
			osp_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = osp_pkg::ST_EVAL;
				end
			end
			osp_pkg::ST_EVAL: begin
				ctl.capture = 1'b1;
				ctl.do_ins  = (op_q == osp_pkg::OP_INS) && !sts.any_eq && !full_set;
				ctl.do_del  = (op_q == osp_pkg::OP_DEL) && sts.any_eq;
				state_d     = osp_pkg::ST_RED;
			end
			osp_pkg::ST_RED: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_out = 1'b1;
					state_d  = osp_pkg::ST_IDLE;
				end
			end
			default: state_d = osp_pkg::ST_IDLE;
		endcase
	end

	// request beat capture
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_q  <= osp_pkg::op_t'(kind);
			key_q <= key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.do_ins) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (ctl.do_del) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			upd_found_s1 <= ctl.do_ins || ctl.do_del;
			full_s1      <= (op_q == osp_pkg::OP_INS) && !sts.any_eq && full_set;
		end
	end

	osp_chain #(
		.CAPACITY (CAPACITY)
	) u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.qkey      (key_q),
		.cnt       (cnt_q),
		.sts       (sts),
		.res_value (res_value)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			value_q <= res_value;
			found_q <= upd_found_s1 || sts.hit;
			full_q  <= full_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign value     = value_q;
	assign found     = found_q;
	assign full_res  = full_q;

	`OSP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(CAPACITY), "key count above capacity")
	`OSP_ASSERT_NOW(a_full_not_found, rsp_valid && full_res, !found, "refused insert found")
	`OSP_ASSERT_NEXT(a_accept_eval, req_valid && req_ready, state_q == osp_pkg::ST_EVAL, "no eval")
	`OSP_ASSERT_NEXT(a_cnt_quiet, state_q != osp_pkg::ST_EVAL, $stable(cnt_q), "count moved")

endmodule

>>> hdl/osp_cell.sv
// ----------------------------------------------------------------------------
// osp_cell
// One slot of the sorted row: holds a key, compares it to the operation key,
// shifts left or right with its neighbors and flags itself as the answer.
// ----------------------------------------------------------------------------
module osp_cell (
	input  logic                                 clk,
	input  osp_pkg::chain_ctl_t                  ctl,
	input  logic signed [osp_pkg::KEY_W-1:0]     qkey,
	input  logic                                 occ,
	input  logic                                 left_occ,
	input  logic                                 right_occ,
	input  logic                                 left_ge,
	input  logic                                 left_gt,
	input  logic                                 left_below,
	input  logic                                 right_lt,
	input  logic                                 right_le,
	input  logic signed [osp_pkg::KEY_W-1:0]     left_key,
	input  logic signed [osp_pkg::KEY_W-1:0]     right_key,
	output logic signed [osp_pkg::KEY_W-1:0]     stored,
	output logic                                 lt,
	output logic                                 le,
	output logic                                 ge,
	output logic                                 gt,
	output logic                                 eq,
	output logic                                 sel,
	output logic        [osp_pkg::KEY_W-1:0]     pick
);

	logic signed [osp_pkg::KEY_W-1:0] key_q;

	assign stored = key_q;
	assign lt     = occ && (key_q < qkey);
	assign le     = occ && (key_q <= qkey);
	assign eq     = occ && (key_q == qkey);
	assign ge     = occ && !lt;
	assign gt     = occ && !le;

	always_comb begin
		unique case (ctl.op)
			osp_pkg::OP_MIN:     sel = occ && !left_occ;
			osp_pkg::OP_MAX:     sel = occ && !right_occ;
			osp_pkg::OP_SUCC:    sel = gt && !left_gt;
			osp_pkg::OP_SUCC_EQ: sel = ge && !left_ge;
			osp_pkg::OP_PRED:    sel = lt && !right_lt;
			osp_pkg::OP_PRED_EQ: sel = le && !right_le;
			osp_pkg::OP_INS,
			osp_pkg::OP_DEL:     sel = 1'b0;
			default:             sel = 1'b0;
		endcase
	end

	assign pick = sel ? key_q : '0;

	// insert: keys at or above the new one move up, the gap takes the new key
	// delete: keys at or above the removed one move down
	always_ff @(posedge clk) begin
		if (ctl.do_ins) begin
			if (left_ge) begin
				key_q <= left_key;
			end else if (left_below && !lt) begin
				key_q <= qkey;
			end
		end else if (ctl.do_del && ge) begin
			key_q <= right_key;
		end
	end

endmodule

>>> hdl/osp_chain.sv
// ----------------------------------------------------------------------------
// osp_chain
// Row of key cells with neighbor wiring, plus a registered OR tree that
// collects the one selected cell's key.
// ----------------------------------------------------------------------------
module osp_chain #(
	parameter int CAPACITY = osp_pkg::CAPACITY_DEF
) (
	input  logic                                     clk,
	input  osp_pkg::chain_ctl_t                      ctl,
	input  logic signed [osp_pkg::KEY_W-1:0]         qkey,
	input  logic        [$clog2(CAPACITY+1)-1:0]     cnt,
	output osp_pkg::chain_sts_t                      sts,
	output logic        [osp_pkg::KEY_W-1:0]         res_value
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int GRP   = osp_pkg::GRP_CELLS;
	localparam int NGRP  = (CAPACITY + GRP - 1) / GRP;

	logic signed [osp_pkg::KEY_W-1:0] key_a  [CAPACITY];
	logic        [osp_pkg::KEY_W-1:0] pick_a [CAPACITY];
	logic [CAPACITY-1:0] occ_v, lt_v, le_v, ge_v, gt_v, eq_v, sel_v;

	logic [osp_pkg::KEY_W-1:0] grp_val_d  [NGRP];
	logic [NGRP-1:0]           grp_hit_d;
	logic [osp_pkg::KEY_W-1:0] grp_val_s1 [NGRP];
	logic [NGRP-1:0]           grp_hit_s1;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                             l_occ, l_ge, l_gt, l_below;
		logic                             r_occ, r_lt, r_le;
		logic signed [osp_pkg::KEY_W-1:0] l_key, r_key;

		assign occ_v[i] = CNT_W'(i) < cnt;

		if (i == 0) begin : g_first
			assign l_occ   = 1'b0;
			assign l_ge    = 1'b0;
			assign l_gt    = 1'b0;
			assign l_below = 1'b1;
			assign l_key   = '0;
		end else begin : g_left
			assign l_occ   = occ_v[i-1];
			assign l_ge    = ge_v[i-1];
			assign l_gt    = gt_v[i-1];
			assign l_below = lt_v[i-1];
			assign l_key   = key_a[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign r_occ = 1'b0;
			assign r_lt  = 1'b0;
			assign r_le  = 1'b0;
			assign r_key = '0;
		end else begin : g_right
			assign r_occ = occ_v[i+1];
			assign r_lt  = lt_v[i+1];
			assign r_le  = le_v[i+1];
			assign r_key = key_a[i+1];
		end

		osp_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.qkey       (qkey),
			.occ        (occ_v[i]),
			.left_occ   (l_occ),
			.right_occ  (r_occ),
			.left_ge    (l_ge),
			.left_gt    (l_gt),
			.left_below (l_below),
			.right_lt   (r_lt),
			.right_le   (r_le),
			.left_key   (l_key),
			.right_key  (r_key),
			.stored     (key_a[i]),
			.lt         (lt_v[i]),
			.le         (le_v[i]),
			.ge         (ge_v[i]),
			.gt         (gt_v[i]),
			.eq         (eq_v[i]),
			.sel        (sel_v[i]),
			.pick       (pick_a[i])
		);
	end

	// first level of the OR tree: groups of cells
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_val_d[g] = '0;
			grp_hit_d[g] = 1'b0;
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < CAPACITY) begin
					grp_val_d[g] = grp_val_d[g] | pick_a[g*GRP+j];
					grp_hit_d[g] = grp_hit_d[g] | sel_v[g*GRP+j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			grp_val_s1 <= grp_val_d;
			grp_hit_s1 <= grp_hit_d;
		end
	end

	always_comb begin
		res_value = '0;
		for (int g = 0; g < NGRP; g++) begin
			res_value = res_value | grp_val_s1[g];
		end
	end

	assign sts.any_eq = |eq_v;
	assign sts.hit    = |grp_hit_s1;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered set successor / predecessor testbench
// Drives insert, delete, min, max and the four neighbor queries through the
// request channel. A shadow sorted set predicts every answer, and each
// response beat is compared field by field in arrival order. Both channels
// see random gaps, and one long response hold-off backs up the request side.
// ----------------------------------------------------------------------------
module testbench;

	localparam int     CAP         = osp_pkg::CAPACITY_DEF;
	localparam int     POOL_N      = 90;
	localparam int     RAND_ITEMS  = 550;
	localparam int     HOLD_CYCLES = 250;
	localparam int     HOLD_AFTER  = 150;
	localparam longint LIMIT       = 400000;

	typedef logic signed [osp_pkg::KEY_W-1:0] key_t;

	typedef struct {
		key_t value;
		logic found;
		logic full;
	} answer_t;

	// Shadow copy of the sorted set plus the answers still owed by the block.
	class set_tracker;
		key_t    members[$];
		answer_t pending_answers[$];
		int      mismatches;
		int      requests;
		int      answers;
		int      refusals;
		int      peak;

		// First index holding a key >= k, or > k when strict.
		function int lower_idx(key_t k, bit strict);
			for (int i = 0; i < members.size(); i++) begin
				if (strict ? (members[i] > k) : (members[i] >= k))
					return i;
			end
			return members.size();
		endfunction

		function answer_t apply_op(osp_pkg::op_t op, key_t k);
			answer_t a;
			int      lb;
			int      ub;
			int      cnt;
			a.value = '0;
			a.found = 1'b0;
			a.full  = 1'b0;
			lb  = lower_idx(k, 1'b0);
			ub  = lower_idx(k, 1'b1);
			cnt = members.size();
			case (op)
				osp_pkg::OP_INS: begin
					if (!(lb < cnt && members[lb] == k)) begin
						if (cnt >= CAP) begin
							a.full = 1'b1;
						end else begin
							members.insert(lb, k);
							a.found = 1'b1;
						end
					end
				end
				osp_pkg::OP_DEL: begin
					if (lb < cnt && members[lb] == k) begin
						members.delete(lb);
						a.found = 1'b1;
					end
				end
				osp_pkg::OP_MIN: begin
					if (cnt > 0) begin
						a.value = members[0];
						a.found = 1'b1;
					end
				end
				osp_pkg::OP_MAX: begin
					if (cnt > 0) begin
						a.value = members[cnt - 1];
						a.found = 1'b1;
					end
				end
				osp_pkg::OP_SUCC: begin
					if (ub < cnt) begin
						a.value = members[ub];
						a.found = 1'b1;
					end
				end
				osp_pkg::OP_SUCC_EQ: begin
					if (lb < cnt) begin
						a.value = members[lb];
						a.found = 1'b1;
					end
				end
				osp_pkg::OP_PRED: begin
					if (lb > 0) begin
						a.value = members[lb - 1];
						a.found = 1'b1;
					end
				end
				default: begin
					if (ub > 0) begin
						a.value = members[ub - 1];
						a.found = 1'b1;
					end
				end
			endcase
			return a;
		endfunction

		function void note_request(osp_pkg::op_t op, key_t k);
			answer_t a;
			a = apply_op(op, k);
			pending_answers.push_back(a);
			requests++;
			if (a.full)
				refusals++;
			if (members.size() > peak)
				peak = members.size();
		endfunction

		function void check_answer(key_t v, logic f, logic fr);
			answer_t e;
			if (pending_answers.size() == 0) begin
				$display("%0t: response beat with no request outstanding (value %0d found %b full %b)",
					$time, v, f, fr);
				mismatches++;
				return;
			end
			e = pending_answers.pop_front();
			answers++;
			if (v !== e.value) begin
				$display("%0t: value mismatch, expected %0d, actual %0d", $time, e.value, v);
				mismatches++;
			end
			if (f !== e.found) begin
				$display("%0t: found mismatch, expected %b, actual %b", $time, e.found, f);
				mismatches++;
			end
			if (fr !== e.full) begin
				$display("%0t: full_res mismatch, expected %b, actual %b", $time, e.full, fr);
				mismatches++;
			end
		endfunction

		function int pending();
			return pending_answers.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_ready;
	logic        [2:0] kind;
	key_t              key;
	logic              rsp_valid;
	logic              rsp_ready;
	key_t              value;
	logic              found;
	logic              full_res;

	set_tracker tracker;
	key_t       pool[POOL_N];
	int         burst_left;
	longint     cycles;

	ordered_set_succ_pred_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.kind      (kind),
		.key       (key),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.value     (value),
		.found     (found),
		.full_res  (full_res)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly short gaps, a few long ones, and now and then a back-to-back burst.
	function automatic int next_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			burst_left = $urandom_range(10, 30);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic offer(osp_pkg::op_t op, key_t k);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		kind      <= op;
		key       <= k;
		do @(posedge clk); while (!req_ready);
	endtask

	// Both channels are sampled at the edge with pre-edge values.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				tracker.check_answer(value, found, full_res);
			if (req_valid && req_ready)
				tracker.note_request(osp_pkg::op_t'(kind), key);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("%0t: run exceeded %0d cycles, %0d answers outstanding",
				$time, LIMIT, tracker.pending());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Response side: random ready pattern, one long hold-off mid run.
	initial begin
		int  hi;
		int  lo;
		int  r;
		bit  held;
		held      = 1'b0;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!held && tracker.requests >= HOLD_AFTER) begin
				held = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			hi = $urandom_range(1, 25);
			repeat (hi) @(posedge clk);
			r = $urandom_range(0, 99);
			if (r < 30)
				lo = 0;
			else if (r < 65)
				lo = $urandom_range(1, 2);
			else if (r < 93)
				lo = $urandom_range(3, 8);
			else
				lo = $urandom_range(15, 40);
			if (lo > 0) begin
				rsp_ready <= 1'b0;
				repeat (lo) @(posedge clk);
			end
		end
	end

	initial begin
		int           n;
		int           r;
		int           phase;
		int           cursor;
		int           ins_pct;
		int           del_pct;
		osp_pkg::op_t op;
		key_t         k;
		tracker    = new();
		cycles     = 0;
		burst_left = 0;
		cursor     = 0;
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		kind       = '0;
		key        = '0;

		// Key pool: extremes first, the rest spread over the whole range.
		pool[0] = 32'sh8000_0000;
		pool[1] = 32'sh7FFF_FFFF;
		pool[2] = -32'sd1;
		pool[3] = 32'sd0;
		pool[4] = 32'sd1;
		pool[5] = 32'sh8000_0001;
		pool[6] = 32'sh7FFF_FFFE;
		for (n = 7; n < POOL_N; n++)
			pool[n] = $urandom;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty set: every query misses.
		offer(osp_pkg::OP_MIN, 32'sd0);
		offer(osp_pkg::OP_MAX, 32'sd0);
		offer(osp_pkg::OP_SUCC, 32'sd0);
		offer(osp_pkg::OP_SUCC_EQ, 32'sh8000_0000);
		offer(osp_pkg::OP_PRED, 32'sh7FFF_FFFF);
		offer(osp_pkg::OP_PRED_EQ, -32'sd1);
		// Extremes, minus one, zero, then a duplicate and an absent delete.
		offer(osp_pkg::OP_INS, 32'sh8000_0000);
		offer(osp_pkg::OP_INS, 32'sh7FFF_FFFF);
		offer(osp_pkg::OP_INS, -32'sd1);
		offer(osp_pkg::OP_INS, 32'sd0);
		offer(osp_pkg::OP_INS, 32'sd0);
		offer(osp_pkg::OP_DEL, 32'sd5);
		offer(osp_pkg::OP_MIN, 32'sh1234_5678);
		offer(osp_pkg::OP_MAX, -32'sd7);
		// Neighbor queries at and off stored keys, including no-answer ends.
		offer(osp_pkg::OP_SUCC, 32'sh7FFF_FFFF);
		offer(osp_pkg::OP_SUCC, -32'sd1);
		offer(osp_pkg::OP_SUCC_EQ, -32'sd1);
		offer(osp_pkg::OP_PRED, 32'sh8000_0000);
		offer(osp_pkg::OP_PRED, 32'sd0);
		offer(osp_pkg::OP_PRED_EQ, 32'sd0);
		offer(osp_pkg::OP_DEL, -32'sd1);
		offer(osp_pkg::OP_PRED_EQ, -32'sd1);
		offer(osp_pkg::OP_DEL, 32'sh8000_0000);
		offer(osp_pkg::OP_DEL, 32'sh7FFF_FFFF);

		// Phases: fill, mixed, drain, fill, mixed. Fill walks the pool so the
		// set reaches capacity and later inserts are refused.
		for (n = 0; n < RAND_ITEMS; n++) begin
			phase = (n / 110) % 5;
			r     = $urandom_range(0, 99);
			k     = pool[$urandom_range(0, POOL_N - 1)];
			if (phase == 0 || phase == 3) begin
				ins_pct = 80;
				del_pct = 5;
			end else if (phase == 2) begin
				ins_pct = 5;
				del_pct = 65;
			end else begin
				ins_pct = 30;
				del_pct = 25;
			end
			if (r < ins_pct) begin
				op = osp_pkg::OP_INS;
				if (phase == 0 || phase == 3) begin
					k      = pool[cursor];
					cursor = (cursor + 1) % POOL_N;
				end else if ($urandom_range(0, 6) == 0) begin
					k = $urandom;
				end
			end else if (r < ins_pct + del_pct) begin
				op = osp_pkg::OP_DEL;
				if ($urandom_range(0, 4) == 0)
					k = $urandom;
			end else begin
				op = osp_pkg::op_t'($urandom_range(osp_pkg::OP_MIN, osp_pkg::OP_PRED_EQ));
				case ($urandom_range(0, 3))
					0: k = $urandom;
					1: k = k + 1;
					2: k = k - 1;
					default: ;
				endcase
			end
			offer(op, k);
		end
		req_valid <= 1'b0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		$display("Ran %0d operations over all eight kinds, %0d answers compared.",
			tracker.requests, tracker.answers);
		$display("Set peaked at %0d of %0d keys, %0d inserts refused as full;",
			tracker.peak, CAP, tracker.refusals);
		$display("one %0d-cycle response hold-off backed up the request side.", HOLD_CYCLES);
		if (tracker.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/osp_pkg.sv
hdl/osp_cell.sv
hdl/osp_chain.sv
hdl/ordered_set_succ_pred_top.sv
verif/testbench.sv
